// ----- hw/rtl/bqe_pkg.sv -----
// ============================================================================
// bqe_pkg: shared types, constants and saturation helpers
// Fixed point Q16.16 helpers and corner tables for the billboard quad expander.
// ============================================================================
`default_nettype none

package bqe_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE = 3'd4;

    // Register reset values
    localparam logic        RST_ENABLE  = 1'b1;
    localparam logic [31:0] RST_NEAR    = 32'd65536;
    localparam logic [31:0] RST_FAR     = 32'd6553600;
    localparam logic [31:0] RST_X_SCALE = 32'd65536;
    localparam logic [31:0] RST_Y_SCALE = 32'd65536;

    // Corner sequencing: two triangles, six vertices per particle
    localparam int VERTS_PER_QUAD = 6;
    localparam int CNT_W          = 3;
    localparam logic [CNT_W-1:0] LAST_CORNER = CNT_W'(VERTS_PER_QUAD - 1);

    // Bit k set: corner k takes the plus offset (x, y) or the second tex corner (u, v)
    localparam logic [VERTS_PER_QUAD-1:0] DX_PLUS = 6'b010110;
    localparam logic [VERTS_PER_QUAD-1:0] DY_PLUS = 6'b110100;
    localparam logic [VERTS_PER_QUAD-1:0] U_SEL   = 6'b010110;
    localparam logic [VERTS_PER_QUAD-1:0] V_SEL   = 6'b110100;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] z;
        logic [30:0] size;
        logic [31:0] color;
        logic [15:0] u0;
        logic [15:0] v0;
        logic [15:0] u1;
        logic [15:0] v1;
        logic        flast;
    } particle_t;

    typedef struct packed {
        particle_t   p;
        logic [31:0] xs;
        logic [31:0] ys;
    } quad_t;

    // Sign-extend a 32-bit value to 34 bits
    function automatic logic [33:0] sext34(input logic [31:0] a);
        return {{2{a[31]}}, a};
    endfunction

    // Saturate a 34-bit signed value to 32 bits
    function automatic logic [31:0] sat34(input logic [33:0] v);
        logic [31:0] r;
        if (&v[33:31] || ~|v[33:31])
            r = v[31:0];
        else if (v[33])
            r = SAT_MIN;
        else
            r = SAT_MAX;
        return r;
    endfunction

    // Floor-shift a full 64-bit product by 16 and saturate to 32 bits
    function automatic logic [31:0] qsat(input logic [63:0] p);
        logic [31:0] r;
        if (&p[63:47] || ~|p[63:47])
            r = p[47:16];
        else if (p[63])
            r = SAT_MIN;
        else
            r = SAT_MAX;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/billboard_quad_expander_top.sv -----
// ============================================================================
// billboard_quad_expander_top: point-sprite quad expansion
// Output: the six vertices of a particle follow on consecutive cycles.
// Throughput is set by the one-vertex-per-cycle corner sequencer; culled or
//   disabled requests are taken and dropped at entry.
// Reset: asynchronous, clears all valid bits; registers return to their defaults.
// The receiver cannot stall, so busy rises only while the sequencer is occupied.
// ============================================================================
`default_nettype none

module billboard_quad_expander_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // Request channel
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [31:0]                   screen_x,
    input  wire logic [31:0]                   screen_y,
    input  wire logic [31:0]                   depth,
    input  wire logic [30:0]                   point_size,
    input  wire logic [31:0]                   rgba,
    input  wire logic [15:0]                   tex_u0,
    input  wire logic [15:0]                   tex_v0,
    input  wire logic [15:0]                   tex_u1,
    input  wire logic [15:0]                   tex_v1,
    input  wire logic                          frame_last,

    // Configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bqe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data,

    // Vertex output
    output logic                               vertex_valid,
    output logic [31:0]                        vertex_x,
    output logic [31:0]                        vertex_y,
    output logic [31:0]                        vertex_z,
    output logic [31:0]                        vertex_color,
    output logic [15:0]                        vertex_u,
    output logic [15:0]                        vertex_v,
    output logic                               quad_last,
    output logic                               frame_end
);

    // ------------------------------------------------------------------
    // Configuration registers; writes are always taken.
    // ------------------------------------------------------------------
    logic        enable_reg;
    logic [31:0] near_reg;
    logic [31:0] far_reg;
    logic [31:0] xsc_reg;
    logic [31:0] ysc_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= bqe_pkg::RST_ENABLE;
            near_reg   <= bqe_pkg::RST_NEAR;
            far_reg    <= bqe_pkg::RST_FAR;
            xsc_reg    <= bqe_pkg::RST_X_SCALE;
            ysc_reg    <= bqe_pkg::RST_Y_SCALE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bqe_pkg::REG_ENABLE:  enable_reg <= cfg_data[0];
                bqe_pkg::REG_NEAR:    near_reg   <= cfg_data;
                bqe_pkg::REG_FAR:     far_reg    <= cfg_data;
                bqe_pkg::REG_X_SCALE: xsc_reg    <= cfg_data;
                bqe_pkg::REG_Y_SCALE: ysc_reg    <= cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Entry: a request is taken when start is high and busy is low.
    // Drop culled particles (negative depth) and everything while disabled,
    // so they never occupy the sequencer.
    // ------------------------------------------------------------------
    logic               accept;
    logic               enter_valid;
    bqe_pkg::particle_t enter_item;

    assign accept      = start && !busy;
    assign enter_valid = accept && enable_reg && !depth[31];

    assign enter_item.cx    = screen_x;
    assign enter_item.cy    = screen_y;
    assign enter_item.z     = depth;
    assign enter_item.size  = point_size;
    assign enter_item.color = rgba;
    assign enter_item.u0    = tex_u0;
    assign enter_item.v0    = tex_v0;
    assign enter_item.u1    = tex_u1;
    assign enter_item.v1    = tex_v1;
    assign enter_item.flast = frame_last;

    // ------------------------------------------------------------------
    // Pipeline stall: hold every stage while a finished quad waits for the
    // sequencer. Nothing is lost or repeated; the stages simply freeze.
    // ------------------------------------------------------------------
    logic           pipe_valid;
    bqe_pkg::quad_t pipe_quad;
    logic           emit_take;
    logic           stall;

    assign stall = pipe_valid && !emit_take;
    assign busy  = stall;

    bqe_scale_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (!stall),
        .in_valid   (enter_valid),
        .in_item    (enter_item),
        .near_plane (near_reg),
        .far_plane  (far_reg),
        .x_scale    (xsc_reg),
        .y_scale    (ysc_reg),
        .out_valid  (pipe_valid),
        .out_quad   (pipe_quad)
    );

    // Corner sequencer: six registered vertices per quad, one per cycle.
    bqe_vertex_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pipe_valid),
        .in_quad      (pipe_quad),
        .take         (emit_take),
        .vertex_valid (vertex_valid),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .vertex_z     (vertex_z),
        .vertex_color (vertex_color),
        .vertex_u     (vertex_u),
        .vertex_v     (vertex_v),
        .quad_last    (quad_last),
        .frame_end    (frame_end)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A frame mark only rides on the closing vertex of a quad.
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |-> (quad_last && vertex_valid))
        else $error("frame_end outside the closing vertex");

    // Two quad closings can never be adjacent: each quad has six vertices.
    assert property (@(posedge clk) disable iff (!rst_n)
        quad_last |=> !quad_last)
        else $error("quad closed twice in a row");

    // The six vertices of a quad leave on consecutive cycles.
    assert property (@(posedge clk) disable iff (!rst_n)
        (vertex_valid && !quad_last) |=> vertex_valid)
        else $error("gap inside a quad");

    // While busy, the head of the pipe holds its quad.
    assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> (pipe_valid && $stable(pipe_quad)))
        else $error("stalled quad changed");

endmodule

`default_nettype wire

// ----- hw/rtl/bqe_scale_pipe.sv -----
// ============================================================================
// bqe_scale_pipe: half-extent pipeline
// Seven stages: span, depth product, depth term, size product, scale,
// axis products, axis extents. Whole pipe holds while advance is low.
// ============================================================================
`default_nettype none

module bqe_scale_pipe (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire logic                in_valid,
    input  wire bqe_pkg::particle_t  in_item,
    input  wire logic [31:0]         near_plane,
    input  wire logic [31:0]         far_plane,
    input  wire logic [31:0]         x_scale,
    input  wire logic [31:0]         y_scale,
    output logic                     out_valid,
    output bqe_pkg::quad_t           out_quad
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    bqe_pkg::particle_t p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg, p7_reg;

    logic [31:0] span1_reg;
    logic [63:0] prod2_reg;
    logic [31:0] w3_reg;
    logic [63:0] prod4_reg;
    logic [31:0] scale5_reg;
    logic [63:0] px6_reg;
    logic [63:0] py6_reg;
    logic [31:0] xs7_reg;
    logic [31:0] ys7_reg;

    logic [31:0] span_next;
    logic [31:0] w_next;

    assign span_next = bqe_pkg::sat34(bqe_pkg::sext34(near_plane)
                                      - bqe_pkg::sext34(far_plane));
    assign w_next    = bqe_pkg::sat34(bqe_pkg::sext34(bqe_pkg::qsat(prod2_reg))
                                      + bqe_pkg::sext34(far_plane));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_reg     <= in_item;
            span1_reg  <= span_next;
            p2_reg     <= p1_reg;
            prod2_reg  <= $signed(p1_reg.z) * $signed(span1_reg);
            p3_reg     <= p2_reg;
            w3_reg     <= w_next;
            p4_reg     <= p3_reg;
            prod4_reg  <= $signed({1'b0, p3_reg.size}) * $signed(w3_reg);
            p5_reg     <= p4_reg;
            scale5_reg <= bqe_pkg::qsat(prod4_reg);
            p6_reg     <= p5_reg;
            px6_reg    <= $signed(scale5_reg) * $signed(x_scale);
            py6_reg    <= $signed(scale5_reg) * $signed(y_scale);
            p7_reg     <= p6_reg;
            xs7_reg    <= bqe_pkg::qsat(px6_reg);
            ys7_reg    <= bqe_pkg::qsat(py6_reg);
        end
    end

    assign out_valid   = v7_reg;
    assign out_quad.p  = p7_reg;
    assign out_quad.xs = xs7_reg;
    assign out_quad.ys = ys7_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bqe_vertex_emit.sv -----
// ============================================================================
// bqe_vertex_emit: corner sequencer and output register
// Holds one quad and walks its six corners, one registered vertex per cycle.
// ============================================================================
`default_nettype none

module bqe_vertex_emit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire bqe_pkg::quad_t  in_quad,
    output logic                 take,
    output logic                 vertex_valid,
    output logic [31:0]          vertex_x,
    output logic [31:0]          vertex_y,
    output logic [31:0]          vertex_z,
    output logic [31:0]          vertex_color,
    output logic [15:0]          vertex_u,
    output logic [15:0]          vertex_v,
    output logic                 quad_last,
    output logic                 frame_end
);

    logic                          act_reg;
    logic [bqe_pkg::CNT_W-1:0]     cnt_reg;
    bqe_pkg::quad_t                q_reg;

    logic                          valid_reg;
    logic                          qlast_reg;
    logic                          fend_reg;
    logic [31:0]                   x_reg, y_reg, z_reg, color_reg;
    logic [15:0]                   u_reg, v_reg;

    logic                          at_last;
    logic [31:0]                   x_next, y_next;
    logic [15:0]                   u_next, v_next;

    assign at_last = (cnt_reg == bqe_pkg::LAST_CORNER);
    assign take    = !act_reg || at_last;

    assign x_next = bqe_pkg::sat34(bqe_pkg::sext34(q_reg.p.cx)
                    + (bqe_pkg::DX_PLUS[cnt_reg] ? bqe_pkg::sext34(q_reg.xs)
                                                 : -bqe_pkg::sext34(q_reg.xs)));
    assign y_next = bqe_pkg::sat34(bqe_pkg::sext34(q_reg.p.cy)
                    + (bqe_pkg::DY_PLUS[cnt_reg] ? bqe_pkg::sext34(q_reg.ys)
                                                 : -bqe_pkg::sext34(q_reg.ys)));
    assign u_next = bqe_pkg::U_SEL[cnt_reg] ? q_reg.p.u1 : q_reg.p.u0;
    assign v_next = bqe_pkg::V_SEL[cnt_reg] ? q_reg.p.v1 : q_reg.p.v0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg   <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
            qlast_reg <= 1'b0;
            fend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= act_reg;
            qlast_reg <= act_reg && at_last;
            fend_reg  <= act_reg && at_last && q_reg.p.flast;
            if (take)
            begin
                act_reg <= in_valid;
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_valid)
            q_reg <= in_quad;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= q_reg.p.z;
        color_reg <= q_reg.p.color;
        u_reg     <= u_next;
        v_reg     <= v_next;
    end

    assign vertex_valid = valid_reg;
    assign vertex_x     = x_reg;
    assign vertex_y     = y_reg;
    assign vertex_z     = z_reg;
    assign vertex_color = color_reg;
    assign vertex_u     = u_reg;
    assign vertex_v     = v_reg;
    assign quad_last    = qlast_reg;
    assign frame_end    = fend_reg;

endmodule

`default_nettype wire

// ----- dv/bqe_vertex_sb_pkg.sv -----
// ============================================================================
// bqe_vertex_sb_pkg: vertex scoreboard for the billboard quad expander
// Holds a shadow copy of the projection registers, predicts the six corner
// vertices of each visible particle, and checks the emitted vertex stream
// in order, field by field.
// ============================================================================
package bqe_vertex_sb_pkg;

    typedef struct {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] z;
        logic [30:0] size;
        logic [31:0] color;
        logic [15:0] u0;
        logic [15:0] v0;
        logic [15:0] u1;
        logic [15:0] v1;
        logic        flast;
    } sprite_req_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] color;
        logic [15:0] u;
        logic [15:0] v;
        logic        qlast;
        logic        fend;
    } vertex_t;

    localparam int QUAD_CORNERS = 6;
    localparam int FRAC_W       = 16;

    // Bit k set: corner k lies on the plus side (and takes the second tex corner)
    localparam logic [QUAD_CORNERS-1:0] PLUS_X_CORNERS = 6'b010110;
    localparam logic [QUAD_CORNERS-1:0] PLUS_Y_CORNERS = 6'b110100;

    localparam longint Q32_MAX = 2147483647;
    localparam longint Q32_MIN = -Q32_MAX - 1;

    class vertex_scoreboard;

        bit      enable_r;
        int      near_r;
        int      far_r;
        int      xscale_r;
        int      yscale_r;
        vertex_t expected_q[$];
        int      error_count;

        function new();
            enable_r    = bqe_pkg::RST_ENABLE;
            near_r      = bqe_pkg::RST_NEAR;
            far_r       = bqe_pkg::RST_FAR;
            xscale_r    = bqe_pkg::RST_X_SCALE;
            yscale_r    = bqe_pkg::RST_Y_SCALE;
            error_count = 0;
        endfunction

        function void write_reg(input logic [bqe_pkg::CFG_IDX_W-1:0] idx,
                                input logic [31:0] data);
            case (idx)
                bqe_pkg::REG_ENABLE:  enable_r = data[0];
                bqe_pkg::REG_NEAR:    near_r   = data;
                bqe_pkg::REG_FAR:     far_r    = data;
                bqe_pkg::REG_X_SCALE: xscale_r = data;
                bqe_pkg::REG_Y_SCALE: yscale_r = data;
                default:     ;
            endcase
        endfunction

        static function longint clamp32(input longint v);
            if (v > Q32_MAX)
                return Q32_MAX;
            if (v < Q32_MIN)
                return Q32_MIN;
            return v;
        endfunction

        // Exact product, floor shift by the fraction width, then clamp
        static function longint qmul(input longint a, input longint b);
            return clamp32((a * b) >>> FRAC_W);
        endfunction

        function void note_particle(input sprite_req_t p);
            longint  cx;
            longint  cy;
            longint  zq;
            longint  span;
            longint  depth_term;
            longint  w;
            longint  scale;
            longint  xs;
            longint  ys;
            vertex_t vtx;
            cx = $signed(p.cx);
            cy = $signed(p.cy);
            zq = $signed(p.z);
            if (!enable_r || zq < 0)
                return;
            span       = clamp32(longint'(near_r) - longint'(far_r));
            depth_term = qmul(zq, span);
            w          = clamp32(depth_term + longint'(far_r));
            scale      = qmul(longint'(p.size), w);
            xs         = qmul(scale, longint'(xscale_r));
            ys         = qmul(scale, longint'(yscale_r));
            for (int k = 0; k < QUAD_CORNERS; k++)
            begin
                vtx.x     = 32'(clamp32(cx + (PLUS_X_CORNERS[k] ? xs : -xs)));
                vtx.y     = 32'(clamp32(cy + (PLUS_Y_CORNERS[k] ? ys : -ys)));
                vtx.z     = p.z;
                vtx.color = p.color;
                vtx.u     = PLUS_X_CORNERS[k] ? p.u1 : p.u0;
                vtx.v     = PLUS_Y_CORNERS[k] ? p.v1 : p.v0;
                vtx.qlast = (k == QUAD_CORNERS - 1);
                vtx.fend  = (k == QUAD_CORNERS - 1) && p.flast;
                expected_q.push_back(vtx);
            end
        endfunction

        task report(input string msg);
            error_count++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
            if (got !== want)
                report($sformatf("%s is %h, expected %h", name, got, want));
        endtask

        task check_vertex(input vertex_t got);
            vertex_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("vertex x=%h y=%h with nothing pending", got.x, got.y));
                return;
            end
            want = expected_q.pop_front();
            check_field("vertex_x", got.x, want.x);
            check_field("vertex_y", got.y, want.y);
            check_field("vertex_z", got.z, want.z);
            check_field("vertex_color", got.color, want.color);
            check_field("vertex_u", 32'(got.u), 32'(want.u));
            check_field("vertex_v", 32'(got.v), 32'(want.v));
            check_field("quad_last", 32'(got.qlast), 32'(want.qlast));
            check_field("frame_end", 32'(got.fend), 32'(want.fend));
        endtask

        function int pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

// ----- dv/tb_billboard_quad_expander_top.sv -----
// ============================================================================
// tb_billboard_quad_expander_top: self-checking bench for the quad expander
// Drives particle requests and register writes, predicts the six corner
// vertices of every visible particle and checks each emitted vertex in order.
// A directed opener covers field extremes, culling, the disabled block, the
// unused register index and mirrored scales; random phases follow under
// several register settings, the extremes among them.
// ============================================================================
module tb_billboard_quad_expander_top;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 5;
    // Longest quiet stretch of a correct run is an idle gap or a settle
    // pause; leave a wide margin on top of that.
    localparam int WATCHDOG_LIMIT = 2000;
    // Long enough for the last vertex of a just-taken request to leave
    localparam int SETTLE_CYCLES  = 16;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 50;
    localparam int DISABLED_ITEMS = 15;

    localparam logic [bqe_pkg::CFG_IDX_W-1:0] UNUSED_REG_IDX = 3'd5;

    localparam logic [31:0] Q_ONE   = 32'h0001_0000;
    localparam logic [31:0] Q_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN   = 32'h8000_0000;
    localparam logic [30:0] SZ_MAX  = 31'h7FFF_FFFF;
    localparam logic [15:0] TEX_ONE = 16'h8000;

    typedef enum {
        SET_DEFAULT,
        SET_RANDOM,
        SET_SMALL,
        SET_NEAR_MAX,
        SET_NEAR_MIN,
        SET_MIRRORED,
        SET_DISABLED
    } setting_e;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          start        = 1'b0;
    logic                          busy;
    logic [31:0]                   screen_x     = '0;
    logic [31:0]                   screen_y     = '0;
    logic [31:0]                   depth        = '0;
    logic [30:0]                   point_size   = '0;
    logic [31:0]                   rgba         = '0;
    logic [15:0]                   tex_u0       = '0;
    logic [15:0]                   tex_v0       = '0;
    logic [15:0]                   tex_u1       = '0;
    logic [15:0]                   tex_v1       = '0;
    logic                          frame_last   = 1'b0;
    logic                          cfg_valid    = 1'b0;
    logic                          cfg_ready;
    logic [bqe_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
    logic [31:0]                   cfg_data     = '0;
    logic                          vertex_valid;
    logic [31:0]                   vertex_x;
    logic [31:0]                   vertex_y;
    logic [31:0]                   vertex_z;
    logic [31:0]                   vertex_color;
    logic [15:0]                   vertex_u;
    logic [15:0]                   vertex_v;
    logic                          quad_last;
    logic                          frame_end;

    bqe_vertex_sb_pkg::vertex_scoreboard sb = new();
    bit               idle_on = 1'b0;
    int               stalled_cycles = 0;

    billboard_quad_expander_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .screen_x     (screen_x),
        .screen_y     (screen_y),
        .depth        (depth),
        .point_size   (point_size),
        .rgba         (rgba),
        .tex_u0       (tex_u0),
        .tex_v0       (tex_v0),
        .tex_u1       (tex_u1),
        .tex_v1       (tex_v1),
        .frame_last   (frame_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .vertex_valid (vertex_valid),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .vertex_z     (vertex_z),
        .vertex_color (vertex_color),
        .vertex_u     (vertex_u),
        .vertex_v     (vertex_v),
        .quad_last    (quad_last),
        .frame_end    (frame_end)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Vertex monitor: the receiver never stalls, so every strobed cycle is a
    // result. Sample at the edge that ends the cycle, before the block updates.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : vertex_monitor
        bqe_vertex_sb_pkg::vertex_t seen;
        if (rst_n && vertex_valid)
        begin
            seen.x     = vertex_x;
            seen.y     = vertex_y;
            seen.z     = vertex_z;
            seen.color = vertex_color;
            seen.u     = vertex_u;
            seen.v     = vertex_v;
            seen.qlast = quad_last;
            seen.fend  = frame_end;
            sb.check_vertex(seen);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles in which no request, register write or vertex
    // moves; a hung block ends the run here.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || vertex_valid)
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly modest screen positions, with the rails and full-range noise mixed in
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return $urandom();
            1:       return Q_MAX;
            2:       return Q_MIN;
            default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        endcase
    endfunction

    // Keep most depths visible so the expansion path gets the bulk of the traffic
    function automatic logic [31:0] rand_depth();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return {1'b1, 31'($urandom())};
            2:       return '0;
            3:       return Q_MAX;
            default: return $urandom_range(0, 32'h0002_0000);
        endcase
    endfunction

    function automatic logic [30:0] rand_size();
        case ($urandom_range(0, 7))
            0:       return 31'($urandom());
            1:       return SZ_MAX;
            2:       return '0;
            default: return 31'($urandom_range(0, 32'h0008_0000));
        endcase
    endfunction

    // Texture corners sit in [0, 1.0] but values out of range must pass as well
    function automatic logic [15:0] rand_tex();
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom());
        return 16'($urandom_range(0, 32768));
    endfunction

    function automatic logic [31:0] rand_small();
        return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endfunction

    function automatic bqe_vertex_sb_pkg::sprite_req_t rand_particle();
        bqe_vertex_sb_pkg::sprite_req_t p;
        p.cx    = rand_coord();
        p.cy    = rand_coord();
        p.z     = rand_depth();
        p.size  = rand_size();
        p.color = $urandom();
        p.u0    = rand_tex();
        p.v0    = rand_tex();
        p.u1    = rand_tex();
        p.v1    = rand_tex();
        p.flast = ($urandom_range(0, 7) == 0);
        return p;
    endfunction

    function automatic bqe_vertex_sb_pkg::sprite_req_t make_particle(
        input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] z,
        input logic [30:0] size, input logic [31:0] color,
        input logic [15:0] u0, input logic [15:0] v0,
        input logic [15:0] u1, input logic [15:0] v1, input logic flast);
        bqe_vertex_sb_pkg::sprite_req_t p;
        p.cx    = cx;
        p.cy    = cy;
        p.z     = z;
        p.size  = size;
        p.color = color;
        p.u0    = u0;
        p.v0    = v0;
        p.u1    = u1;
        p.v1    = v1;
        p.flast = flast;
        return p;
    endfunction

    function automatic setting_e phase_setting(input int ph);
        case (ph)
            0:       return SET_RANDOM;
            1:       return SET_NEAR_MAX;
            2:       return SET_SMALL;
            3:       return SET_DISABLED;
            4:       return SET_MIRRORED;
            5:       return SET_NEAR_MIN;
            6:       return SET_RANDOM;
            7:       return SET_DEFAULT;
            8:       return SET_SMALL;
            default: return SET_RANDOM;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Drivers. Every task starts and ends just after a rising edge.
    // ------------------------------------------------------------------------

    // Present one request, hold it until the block takes it, then log it.
    // Start stays high into the next request unless an idle burst or a settle comes first.
    task automatic send_particle(input bqe_vertex_sb_pkg::sprite_req_t p);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        start      <= 1'b1;
        screen_x   <= p.cx;
        screen_y   <= p.cy;
        depth      <= p.z;
        point_size <= p.size;
        rgba       <= p.color;
        tex_u0     <= p.u0;
        tex_v0     <= p.v0;
        tex_u1     <= p.u1;
        tex_v1     <= p.v1;
        frame_last <= p.flast;
        do
            @(posedge clk);
        while (busy);
        sb.note_particle(p);
    endtask

    // Drop start and wait until the block is drained; culled requests leave
    // nothing pending, so also sit out the pipeline depth.
    task automatic settle();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Hold one register write until it is taken; the caller drops valid
    task automatic write_cfg(input logic [bqe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_setting(input setting_e s);
        logic        en;
        logic [31:0] nr;
        logic [31:0] fr;
        logic [31:0] xr;
        logic [31:0] yr;
        en = 1'b1;
        case (s)
            SET_DEFAULT:
            begin
                en = bqe_pkg::RST_ENABLE;
                nr = bqe_pkg::RST_NEAR;
                fr = bqe_pkg::RST_FAR;
                xr = bqe_pkg::RST_X_SCALE;
                yr = bqe_pkg::RST_Y_SCALE;
            end
            SET_SMALL:
            begin
                nr = rand_small();
                fr = rand_small();
                xr = rand_small();
                yr = rand_small();
            end
            SET_NEAR_MAX:
            begin
                nr = Q_MAX;
                fr = Q_MIN;
                xr = Q_MAX;
                yr = Q_MAX;
            end
            SET_NEAR_MIN:
            begin
                nr = Q_MIN;
                fr = Q_MAX;
                xr = Q_MIN;
                yr = Q_MIN;
            end
            SET_MIRRORED:
            begin
                // near 0.1, far 50.0, negative scales flip the quad
                nr = 32'd6554;
                fr = 32'h0032_0000;
                xr = 32'hFFFE_0000;
                yr = 32'hFFFF_8000;
            end
            SET_DISABLED:
            begin
                en = 1'b0;
                nr = $urandom();
                fr = $urandom();
                xr = $urandom();
                yr = $urandom();
            end
            default:
            begin
                nr = $urandom();
                fr = $urandom();
                xr = $urandom();
                yr = $urandom();
            end
        endcase
        settle();
        write_cfg(bqe_pkg::REG_ENABLE, {31'b0, en});
        write_cfg(bqe_pkg::REG_NEAR, nr);
        write_cfg(bqe_pkg::REG_FAR, fr);
        write_cfg(bqe_pkg::REG_X_SCALE, xr);
        write_cfg(bqe_pkg::REG_Y_SCALE, yr);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Directed opener under the reset settings, then the special cases
    // ------------------------------------------------------------------------
    task automatic directed_checks();
        bqe_vertex_sb_pkg::sprite_req_t typical;
        typical = make_particle(32'h0064_0000, 32'h0032_0000, 32'h0000_8000, 31'h0001_0000,
                                32'hFF80_4020, 16'h0000, 16'h0000, TEX_ONE, TEX_ONE, 1'b0);
        idle_on = 1'b0;
        // all-zero particle at the far plane
        send_particle(make_particle('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0));
        // ordinary particle closing a frame
        typical.flast = 1'b1;
        send_particle(typical);
        typical.flast = 1'b0;
        // culled: depth just below zero, frame mark must vanish with it
        send_particle(make_particle(Q_ONE, Q_ONE, 32'hFFFF_FFFF, SZ_MAX, $urandom(),
                                    TEX_ONE, TEX_ONE, TEX_ONE, TEX_ONE, 1'b1));
        send_particle(make_particle(Q_MAX, Q_MIN, Q_MIN, SZ_MAX, '1, '1, '1, '1, '1, 1'b0));
        // rails on the position, depth, size and color fields: saturate both axes
        send_particle(make_particle(Q_MAX, Q_MIN, Q_MAX, SZ_MAX, 32'hFFFF_FFFF,
                                    TEX_ONE, TEX_ONE, TEX_ONE, TEX_ONE, 1'b1));
        send_particle(make_particle(Q_MIN, Q_MAX, '0, SZ_MAX, '0, '0, '0, '0, '0, 1'b0));
        // zero size collapses the quad; texture values beyond 1.0 pass through
        send_particle(make_particle(32'h1234_5678, 32'hEDCB_A988, Q_ONE, '0, 32'h5A5A_A5A5,
                                    16'hFFFF, 16'h7FFF, 16'h0001, 16'hFFFF, 1'b0));
        // depth exactly 1.0 lands on the near value
        send_particle(make_particle(32'hFFF0_0000, 32'h0010_0000, Q_ONE, 31'h0002_8000,
                                    $urandom(), 16'h4000, 16'h2000, 16'h6000, 16'h7000, 1'b0));

        // a write past the register list must change nothing
        settle();
        write_cfg(UNUSED_REG_IDX, $urandom());
        cfg_valid <= 1'b0;
        send_particle(typical);

        // disabled block swallows everything, frame marks included
        apply_setting(SET_DISABLED);
        typical.flast = 1'b1;
        send_particle(typical);
        typical.flast = 1'b0;
        send_particle(typical);

        // negative size factors mirror the quad
        apply_setting(SET_MIRRORED);
        send_particle(typical);
        send_particle(make_particle(Q_MAX, Q_MIN, 32'h0000_4000, 31'h0100_0000, $urandom(),
                                    '0, TEX_ONE, TEX_ONE, '0, 1'b1));

        // register extremes: span and scales pinned to the rails
        apply_setting(SET_NEAR_MAX);
        send_particle(typical);
        apply_setting(SET_NEAR_MIN);
        send_particle(typical);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_checks();

        // Random phases; the last ones run back to back with no idling, and
        // one early small-value phase does too.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            apply_setting(phase_setting(ph));
            idle_on = !(ph == 2 || ph >= NUM_PHASES - 2);
            repeat (phase_setting(ph) == SET_DISABLED ? DISABLED_ITEMS : PHASE_ITEMS)
                send_particle(rand_particle());
        end

        // Drain every pending vertex, then watch a little longer for strays
        settle();

        if (sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
